>>> hw/rtl/etvc_pkg.sv
// Shared types and constants for the Ethernet VLAN header classifier.
package etvc_pkg;

	localparam int CNT_W       = 32;
	localparam int ETYPE_W     = 16;
	localparam int POS_W       = 6;
	localparam int TAGS_W      = 4;
	localparam int NUM_CLASSES = 6;

	typedef logic [2:0]         class_t;
	typedef logic [ETYPE_W-1:0] etype_t;
	typedef logic [POS_W-1:0]   pos_t;
	typedef logic [CNT_W-1:0]   cnt_t;

	localparam class_t CLS_IPV4      = 3'd0;
	localparam class_t CLS_ARP       = 3'd1;
	localparam class_t CLS_IPV6      = 3'd2;
	localparam class_t CLS_OTHER     = 3'd3;
	localparam class_t CLS_TOO_SHORT = 3'd4;
	localparam class_t CLS_TOO_MANY  = 3'd5;

	localparam etype_t ETYPE_IPV4 = 16'h0800;
	localparam etype_t ETYPE_ARP  = 16'h0806;
	localparam etype_t ETYPE_IPV6 = 16'h86DD;
	localparam etype_t ETYPE_VLAN = 16'h8100;

	localparam pos_t POS_TYPE_HI = 6'd12;
	localparam pos_t POS_TYPE_LO = 6'd13;
	localparam pos_t POS_TAG0    = 6'd14;

	function automatic class_t class_of(etype_t et);
		class_t c;
		case (et)
			ETYPE_IPV4: c = CLS_IPV4;
			ETYPE_ARP:  c = CLS_ARP;
			ETYPE_IPV6: c = CLS_IPV6;
			default:    c = CLS_OTHER;
		endcase
		return c;
	endfunction

endpackage

>>> hw/rtl/etvc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module etvc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 28,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic             rd_en,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

>>> hw/rtl/ethernet_vlan_header_classifier.sv
// Top level of the Ethernet VLAN header classifier: parser, counter update, result register.
//
// Takes one frame byte per cycle when in_stall is low, skips the MAC addresses, pops up to
// MAX_TAGS stacked 0x8100 tags and classifies the frame as IPv4, ARP, IPv6, other, too short
// or too many tags, giving one result per frame with per-port wrapping 32-bit counts. The
// input stalls while stage 1 is full and the result register is held by out_stall. The
// counter RAM read and stage 1 register the resolving byte's result, then the increment
// feeds the result register. Counters start at zero after reset with no clearing pass.
module ethernet_vlan_header_classifier #(
	parameter int NUM_PORTS = 4,
	parameter int MAX_TAGS  = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [7:0]            data_byte,
	input  logic                  last_byte,
	input  logic [1:0]            port,
	output logic                  out_valid,
	input  logic                  out_stall,
	output etvc_pkg::class_t      frame_class,
	output logic                  tag_seen,
	output logic [15:0]           inner_tci,
	output etvc_pkg::pos_t        payload_offset,
	output etvc_pkg::cnt_t        class_count,
	output etvc_pkg::cnt_t        tagged_count
);

	import etvc_pkg::*;

	localparam int PW     = (NUM_PORTS > 1) ? $clog2(NUM_PORTS) : 1;
	localparam int CDEPTH = NUM_PORTS * NUM_CLASSES;
	localparam int CAW    = $clog2(CDEPTH);

	// parser state
	pos_t                pos_q;
	etype_t              type_q;
	logic [15:0]         tci_q;
	logic [TAGS_W-1:0]   tags_q;
	logic                resolved_q;

	// parser combinational results
	logic                accept;
	etype_t              type_nx;
	logic [15:0]         tci_nx;
	logic [TAGS_W-1:0]   tags_nx;
	logic                check;
	logic                vlan_frame;
	logic                seen;
	logic                emit;
	logic                resolve;
	class_t              cls;
	logic [PW-1:0]       port_idx;
	logic [CAW-1:0]      class_addr;

	// stage 1
	logic                s1_free;
	logic                adv;
	logic                valid_s1;
	class_t              class_s1;
	logic                seen_s1;
	logic                tagged_s1;
	logic [15:0]         tci_s1;
	pos_t                off_s1;
	logic [CAW-1:0]      caddr_s1;
	logic [PW-1:0]       port_s1;
	logic                cvld_s1;
	logic                tvld_s1;
	cnt_t                crd;
	cnt_t                trd;
	cnt_t                ccur;
	cnt_t                tcur;
	cnt_t                cnew;
	cnt_t                tnew;

	// counter bookkeeping
	logic [CDEPTH-1:0]   cvld_q;
	logic [NUM_PORTS-1:0] tvld_q;
	logic                cfwd_vld_q;
	logic [CAW-1:0]      cfwd_addr_q;
	cnt_t                cfwd_data_q;
	logic                tfwd_vld_q;
	logic [PW-1:0]       tfwd_addr_q;
	cnt_t                tfwd_data_q;

	// output register
	logic                out_valid_q;

	assign accept  = in_valid && !in_stall;
	assign adv     = !out_valid_q || !out_stall;
	assign s1_free = !valid_s1 || adv;
	assign in_stall = !s1_free;

	always_comb begin
		if (32'(port) >= NUM_PORTS) begin
			port_idx = PW'(NUM_PORTS - 1);
		end else begin
			port_idx = PW'(port);
		end
	end

	always_comb begin
		type_nx = type_q;
		tci_nx  = tci_q;
		tags_nx = tags_q;
		check   = 1'b0;
		if (pos_q == POS_TYPE_HI || pos_q == POS_TYPE_LO) begin
			type_nx = {type_q[7:0], data_byte};
			check   = (pos_q == POS_TYPE_LO);
		end else if (pos_q >= POS_TAG0) begin
			if (pos_q[1]) begin
				tci_nx = {tci_q[7:0], data_byte};
			end else begin
				type_nx = {type_q[7:0], data_byte};
				if (pos_q[0]) begin
					tags_nx = tags_q + TAGS_W'(1);
					check   = 1'b1;
				end
			end
		end
		vlan_frame = (pos_q >= POS_TAG0) || (pos_q == POS_TYPE_LO && type_nx == ETYPE_VLAN);
		seen    = (tags_nx != '0);
		resolve = 1'b0;
		cls     = CLS_TOO_SHORT;
		if (check && type_nx != ETYPE_VLAN) begin
			resolve = 1'b1;
			cls     = class_of(type_nx);
		end else if (check && 32'(tags_nx) >= MAX_TAGS) begin
			resolve = 1'b1;
			cls     = CLS_TOO_MANY;
		end
		emit = !resolved_q && (resolve || last_byte);
	end

	assign class_addr = CAW'(port_idx) * CAW'(NUM_CLASSES) + CAW'(cls);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			type_q     <= '0;
			tci_q      <= '0;
			tags_q     <= '0;
			resolved_q <= 1'b0;
		end else if (accept) begin
			if (last_byte) begin
				pos_q      <= '0;
				type_q     <= '0;
				tci_q      <= '0;
				tags_q     <= '0;
				resolved_q <= 1'b0;
			end else if (!resolved_q) begin
				type_q     <= type_nx;
				tci_q      <= tci_nx;
				tags_q     <= tags_nx;
				resolved_q <= resolve;
				if (!resolve) begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	etvc_ram #(
		.WIDTH (CNT_W),
		.DEPTH (CDEPTH)
	) u_class_ram (
		.clk     (clk),
		.wr_en   (valid_s1 && adv),
		.wr_addr (caddr_s1),
		.wr_data (cnew),
		.rd_en   (accept && emit),
		.rd_addr (class_addr),
		.rd_data (crd)
	);

	etvc_ram #(
		.WIDTH (CNT_W),
		.DEPTH (NUM_PORTS),
		.AW    (PW)
	) u_tagged_ram (
		.clk     (clk),
		.wr_en   (valid_s1 && adv && tagged_s1),
		.wr_addr (port_s1),
		.wr_data (tnew),
		.rd_en   (accept && emit),
		.rd_addr (port_idx),
		.rd_data (trd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_free) begin
			valid_s1 <= accept && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit && s1_free) begin
			class_s1  <= cls;
			seen_s1   <= resolve && seen;
			tagged_s1 <= vlan_frame;
			tci_s1    <= (resolve && seen) ? tci_nx : 16'd0;
			off_s1    <= resolve ? pos_q + POS_W'(1) : '0;
			caddr_s1  <= class_addr;
			port_s1   <= port_idx;
			cvld_s1   <= cvld_q[class_addr];
			tvld_s1   <= tvld_q[port_idx];
		end
	end

	always_comb begin
		if (cfwd_vld_q && cfwd_addr_q == caddr_s1) begin
			ccur = cfwd_data_q;
		end else if (cvld_s1) begin
			ccur = crd;
		end else begin
			ccur = '0;
		end
		if (tfwd_vld_q && tfwd_addr_q == port_s1) begin
			tcur = tfwd_data_q;
		end else if (tvld_s1) begin
			tcur = trd;
		end else begin
			tcur = '0;
		end
		cnew = ccur + CNT_W'(1);
		tnew = tagged_s1 ? tcur + CNT_W'(1) : tcur;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cvld_q     <= '0;
			tvld_q     <= '0;
			cfwd_vld_q <= 1'b0;
			tfwd_vld_q <= 1'b0;
		end else if (valid_s1 && adv) begin
			cvld_q[caddr_s1] <= 1'b1;
			cfwd_vld_q       <= 1'b1;
			if (tagged_s1) begin
				tvld_q[port_s1] <= 1'b1;
				tfwd_vld_q      <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && adv) begin
			cfwd_addr_q <= caddr_s1;
			cfwd_data_q <= cnew;
			if (tagged_s1) begin
				tfwd_addr_q <= port_s1;
				tfwd_data_q <= tnew;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			frame_class    <= class_s1;
			tag_seen       <= seen_s1;
			inner_tci      <= tci_s1;
			payload_offset <= off_s1;
			class_count    <= cnew;
			tagged_count   <= tnew;
		end
	end

	assign out_valid = out_valid_q;

endmodule

>>> dv/ethernet_vlan_header_classifier_tb.sv
// Self-checking testbench for the Ethernet VLAN header classifier with a scoreboard class.
`timescale 1ns / 100ps

module ethernet_vlan_header_classifier_tb;
	import etvc_pkg::*;

	localparam int NUM_PORTS     = 4;
	localparam int MAX_TAGS      = 8;
	localparam int CTRS_PER_PORT = 7;
	localparam int TAGGED_SLOT   = 6;
	localparam int RAND_BYTES    = 540;
	localparam int LONG_HOLD     = 400;
	localparam int DRAIN_CYCLES  = 16;
	localparam int MAX_REPORTS   = 10;

	typedef struct {
		class_t      cls;
		logic        seen;
		logic [15:0] tci;
		pos_t        offset;
		cnt_t        cls_cnt;
		cnt_t        tag_cnt;
	} hdr_result_t;

	typedef enum int {STALL_NONE, STALL_HALF, STALL_RARE, STALL_PERIODIC} stall_mode_t;
	typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

	class header_scoreboard;
		pos_t                 hdr_pos;
		etype_t               type_sr;
		logic [15:0]          tci_sr;
		logic [TAGS_W-1:0]    tags;
		bit                   resolved;
		cnt_t                 counters[NUM_PORTS*CTRS_PER_PORT];
		hdr_result_t          expected_q[$];
		int                   predicted;
		int                   checked;
		int                   mismatches;
		int                   class_hits[NUM_CLASSES];

		function new();
			foreach (counters[i]) counters[i] = '0;
			foreach (class_hits[i]) class_hits[i] = 0;
			predicted  = 0;
			checked    = 0;
			mismatches = 0;
			end_frame();
		endfunction

		function void end_frame();
			hdr_pos  = '0;
			type_sr  = '0;
			tci_sr   = '0;
			tags     = '0;
			resolved = 1'b0;
		endfunction

		function class_t etype_class(etype_t et);
			if (et == ETYPE_IPV4)
				return CLS_IPV4;
			if (et == ETYPE_ARP)
				return CLS_ARP;
			if (et == ETYPE_IPV6)
				return CLS_IPV6;
			return CLS_OTHER;
		endfunction

		function void add_result(int p, class_t cls, bit is_vlan, logic seen, logic [15:0] tci,
				pos_t off);
			hdr_result_t r;
			int base;
			base = p * CTRS_PER_PORT;
			counters[base + cls] = counters[base + cls] + 1'b1;
			if (is_vlan)
				counters[base + TAGGED_SLOT] = counters[base + TAGGED_SLOT] + 1'b1;
			r.cls     = cls;
			r.seen    = seen;
			r.tci     = tci;
			r.offset  = off;
			r.cls_cnt = counters[base + cls];
			r.tag_cnt = counters[base + TAGGED_SLOT];
			expected_q.push_back(r);
			predicted++;
			class_hits[cls]++;
		endfunction

		function void note_byte(logic [7:0] b, logic last, logic [1:0] prt);
			int          p;
			pos_t        at;
			logic [1:0]  phase;
			bit          check;
			bit          is_vlan;
			logic        seen;
			logic [15:0] tci;
			p = prt;
			if (p >= NUM_PORTS)
				p = NUM_PORTS - 1;
			if (resolved) begin
				if (last)
					end_frame();
				return;
			end
			at    = hdr_pos;
			check = 1'b0;
			if (at == POS_TYPE_HI || at == POS_TYPE_LO) begin
				type_sr = {type_sr[7:0], b};
				check   = (at == POS_TYPE_LO);
			end else if (at >= POS_TAG0) begin
				phase = 2'(at - POS_TAG0);
				if (phase < 2'd2) begin
					tci_sr = {tci_sr[7:0], b};
				end else begin
					type_sr = {type_sr[7:0], b};
					if (phase == 2'd3) begin
						tags  = tags + 1'b1;
						check = 1'b1;
					end
				end
			end
			is_vlan = (at >= POS_TAG0) || (at == POS_TYPE_LO && type_sr == ETYPE_VLAN);
			seen    = (tags != '0);
			tci     = seen ? tci_sr : 16'h0000;
			if (check && type_sr != ETYPE_VLAN) begin
				add_result(p, etype_class(type_sr), is_vlan, seen, tci, at + 1'b1);
				resolved = 1'b1;
			end else if (check && tags >= MAX_TAGS) begin
				add_result(p, CLS_TOO_MANY, is_vlan, seen, tci, at + 1'b1);
				resolved = 1'b1;
			end else if (last) begin
				add_result(p, CLS_TOO_SHORT, is_vlan, 1'b0, 16'h0000, '0);
			end
			if (last)
				end_frame();
			else if (!resolved)
				hdr_pos = at + 1'b1;
		endfunction

		function void check_result(hdr_result_t act);
			hdr_result_t want;
			if (expected_q.size() == 0) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS)
					$display("%0t: unexpected result class %0d tci %h off %0d", $realtime,
						act.cls, act.tci, act.offset);
				return;
			end
			want = expected_q.pop_front();
			checked++;
			if (want.cls !== act.cls || want.seen !== act.seen || want.tci !== act.tci ||
					want.offset !== act.offset || want.cls_cnt !== act.cls_cnt ||
					want.tag_cnt !== act.tag_cnt) begin
				mismatches++;
				if (mismatches <= MAX_REPORTS) begin
					$display("%0t: result %0d mismatch", $realtime, checked);
					$display("  expected class %0d seen %b tci %h off %0d count %0d tagged %0d",
						want.cls, want.seen, want.tci, want.offset, want.cls_cnt, want.tag_cnt);
					$display("  actual   class %0d seen %b tci %h off %0d count %0d tagged %0d",
						act.cls, act.seen, act.tci, act.offset, act.cls_cnt, act.tag_cnt);
				end
			end
		endfunction

		function void drain_check();
			if (expected_q.size() != 0) begin
				$display("%0d expected results never arrived", expected_q.size());
				mismatches += expected_q.size();
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [7:0]  data_byte = '0;
	logic        last_byte = 1'b0;
	logic [1:0]  port = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	class_t      frame_class;
	logic        tag_seen;
	logic [15:0] inner_tci;
	pos_t        payload_offset;
	cnt_t        class_count;
	cnt_t        tagged_count;

	header_scoreboard sb = new();
	hdr_result_t      got;

	stall_mode_t stall_mode = STALL_NONE;
	int          hold_requests = 0;
	int          holds_done = 0;
	int          hold_left = 0;
	logic [3:0]  stall_tick = '0;

	int burst_left = 0;
	bit gaps_on = 1'b0;
	int bytes_sent = 0;
	int frames_sent = 0;

	ethernet_vlan_header_classifier #(
		.NUM_PORTS(NUM_PORTS),
		.MAX_TAGS (MAX_TAGS)
	) dut (.*);

	always #6 clk = ~clk;

	initial begin
		#(5_000_000);
		$display("FAIL ethernet_vlan_header_classifier");
		$finish;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				sb.note_byte(data_byte, last_byte, port);
			if (out_valid && !out_stall) begin
				got.cls     = frame_class;
				got.seen    = tag_seen;
				got.tci     = inner_tci;
				got.offset  = payload_offset;
				got.cls_cnt = class_count;
				got.tag_cnt = tagged_count;
				sb.check_result(got);
			end
		end
	end

	// receiver: long hold on request, otherwise the current stall pattern
	always @(posedge clk) begin
		stall_tick <= stall_tick + 1'b1;
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (holds_done != hold_requests) begin
			holds_done <= holds_done + 1;
			hold_left  <= LONG_HOLD;
			out_stall  <= 1'b1;
		end else begin
			case (stall_mode)
				STALL_HALF:     out_stall <= 1'($urandom_range(0, 1));
				STALL_RARE:     out_stall <= ($urandom_range(0, 7) == 0);
				STALL_PERIODIC: out_stall <= (stall_tick < 4'd5);
				default:        out_stall <= 1'b0;
			endcase
		end
	end

	function automatic logic [7:0] fill_byte(fill_t f);
		case (f)
			FILL_ZERO: return 8'h00;
			FILL_ONES: return 8'hFF;
			default:   return 8'($urandom);
		endcase
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic l, input logic [1:0] p);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = gaps_on ? $urandom_range(0, 6) : 0;
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid  <= 1'b1;
		data_byte <= b;
		last_byte <= l;
		port      <= p;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		bytes_sent++;
	endtask

	task automatic send_frame(input int n_tags, input etype_t final_type, input int tail_len,
			input int cut_len, input logic [1:0] p, input fill_t fill);
		logic [7:0]  fb[$];
		logic [15:0] tci;
		etype_t      vlan;
		vlan = ETYPE_VLAN;
		repeat (12) fb.push_back(fill_byte(fill));
		repeat (n_tags) begin
			tci = {fill_byte(fill), fill_byte(fill)};
			fb.push_back(vlan[15:8]);
			fb.push_back(vlan[7:0]);
			fb.push_back(tci[15:8]);
			fb.push_back(tci[7:0]);
		end
		fb.push_back(final_type[15:8]);
		fb.push_back(final_type[7:0]);
		repeat (tail_len) fb.push_back(fill_byte(fill));
		if (cut_len > 0)
			while (fb.size() > cut_len) void'(fb.pop_back());
		foreach (fb[i])
			send_byte(fb[i], i == fb.size() - 1, p);
		frames_sent++;
	endtask

	task automatic send_noise(input int len);
		for (int i = 0; i < len; i++)
			send_byte(8'($urandom), i == len - 1, 2'($urandom));
		frames_sent++;
	endtask

	function automatic etype_t pick_type();
		case ($urandom_range(0, 4))
			0:       return ETYPE_IPV4;
			1:       return ETYPE_ARP;
			2:       return ETYPE_IPV6;
			3:       return ETYPE_IPV4 ^ (16'h0001 << $urandom_range(0, 15));
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic int pick_tags();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return 0;
		if (r < 7)
			return 1;
		if (r == 7)
			return $urandom_range(2, 4);
		if (r == 8)
			return $urandom_range(5, MAX_TAGS);
		return $urandom_range(MAX_TAGS + 1, MAX_TAGS + 3);
	endfunction

	initial begin
		int start_bytes;
		int n_tags;
		int tail;
		int kind;
		int rand_frames;
		int hold_at;

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_frame(0, ETYPE_IPV4, 4, 0, 2'd0, FILL_ZERO);
		send_frame(1, ETYPE_ARP, 2, 0, 2'd3, FILL_ONES);
		send_frame(2, ETYPE_IPV6, 0, 0, 2'd1, FILL_RANDOM);
		send_frame(0, 16'hFFFF, 3, 0, 2'd2, FILL_ONES);
		send_frame(0, ETYPE_IPV4, 0, 1, 2'd0, FILL_RANDOM);
		send_frame(0, ETYPE_IPV4, 0, 13, 2'd1, FILL_RANDOM);
		send_frame(1, ETYPE_IPV4, 0, 14, 2'd2, FILL_RANDOM);
		send_frame(1, ETYPE_IPV4, 0, 16, 2'd3, FILL_RANDOM);
		send_frame(2, ETYPE_ARP, 0, 18, 2'd1, FILL_RANDOM);
		send_frame(MAX_TAGS, ETYPE_IPV4, 2, 0, 2'd0, FILL_RANDOM);
		send_frame(MAX_TAGS + 1, ETYPE_IPV4, 3, 0, 2'd3, FILL_ONES);
		send_frame(MAX_TAGS + 3, ETYPE_IPV6, 0, 0, 2'd2, FILL_RANDOM);

		start_bytes = bytes_sent;
		rand_frames = 0;
		hold_at     = $urandom_range(2, 6);
		gaps_on     = 1'b1;
		while (bytes_sent - start_bytes < RAND_BYTES) begin
			if (rand_frames == hold_at) begin
				hold_requests <= hold_requests + 1;
				gaps_on = 1'b0;
			end else if ($urandom_range(0, 5) == 0) begin
				gaps_on = 1'($urandom_range(0, 1));
				stall_mode <= stall_mode_t'($urandom_range(0, 3));
			end
			n_tags = pick_tags();
			tail   = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
			kind   = $urandom_range(0, 19);
			if (kind < 14)
				send_frame(n_tags, pick_type(), tail, 0, 2'($urandom), FILL_RANDOM);
			else if (kind < 17)
				send_frame(n_tags, pick_type(), tail, $urandom_range(1, 15 + 4 * n_tags),
					2'($urandom), FILL_RANDOM);
			else
				send_noise($urandom_range(1, 30));
			rand_frames++;
		end
		in_valid   <= 1'b0;
		stall_mode <= STALL_NONE;

		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		sb.drain_check();

		$display("Sent %0d bytes in %0d frames; %0d header results checked.",
			bytes_sent, frames_sent, sb.checked);
		$display("Class hits ipv4 %0d arp %0d ipv6 %0d other %0d short %0d many-tags %0d",
			sb.class_hits[CLS_IPV4], sb.class_hits[CLS_ARP], sb.class_hits[CLS_IPV6],
			sb.class_hits[CLS_OTHER], sb.class_hits[CLS_TOO_SHORT], sb.class_hits[CLS_TOO_MANY]);
		if (sb.mismatches == 0)
			$display("PASS ethernet_vlan_header_classifier");
		else
			$display("FAIL ethernet_vlan_header_classifier");
		$finish;
	end

endmodule
